>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define OSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define OSD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/osdgc_pkg.sv
`timescale 1ns / 1ps

package osdgc_pkg;

   localparam int PIX_W       = 14;   // pixel index width
   localparam int DIM_W       = 7;    // glyph size, half size, line length, slot numbers
   localparam int CODE_W      = 4;    // stored glyph code
   localparam int CSR_AW      = 4;
   localparam int GLYPH_COUNT = 13;

   localparam logic [CODE_W-1:0] CODE_DASH  = 4'd10;
   localparam logic [CODE_W-1:0] CODE_SPACE = 4'd11;
   localparam logic [CODE_W-1:0] CODE_COLON = 4'd12;
   localparam logic [CODE_W-1:0] CODE_BAD   = CODE_W'(GLYPH_COUNT);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef enum logic [1:0] {
      CMD_GLYPH  = 2'd0,
      CMD_TEXT   = 2'd1,
      CMD_RENDER = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_GLYPH_SIZE  = 2'd0,
      REG_ROTATE      = 2'd1,
      REG_ALPHA       = 2'd2,
      REG_TEXT_LENGTH = 2'd3
   } reg_idx_type;

   function automatic logic [CODE_W-1:0] char_to_code(input logic [7:0] ch);
      logic [CODE_W-1:0] code;
      code = CODE_BAD;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         code = CODE_W'(ch - CHAR_ZERO);
      end else if (ch == CHAR_DASH) begin
         code = CODE_DASH;
      end else if (ch == CHAR_SPACE) begin
         code = CODE_SPACE;
      end else if (ch == CHAR_COLON) begin
         code = CODE_COLON;
      end
      return code;
   endfunction

endpackage

>>> rtl/core/osdgc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module osdgc_div #(
   parameter int DEN_W = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [osdgc_pkg::PIX_W-1:0]  num,
   input  logic [DEN_W-1:0]             den,
   output logic                         done,
   output logic [osdgc_pkg::PIX_W-1:0]  quo,
   output logic [DEN_W-1:0]             rem
);

   localparam int NW    = osdgc_pkg::PIX_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NW-1:0]    num_ff;     // dividend shifts out, quotient shifts in
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic [DEN_W-1:0] rem_in;
   logic             qbit;

   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      qbit    = ~diff[DEN_W];
      rem_in  = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NW);
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NW-2:0], qbit};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;
   assign rem  = rem_ff;

endmodule

>>> rtl/core/osd_glyph_text_compositor.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  | Signals                                         | Moves
// ---------+-------------------------------------------------+---------------------------
// req      | req_valid/req_ready, req_cmd ... req_pixel_index | glyph write, text write,
//          |                                                  | render request
// rsp      | rsp_valid/rsp_ready, rsp_low_byte, rsp_high_byte,| one ARGB4444 pixel per
//          | rsp_bad_char                                     | render request
// csr      | csr_psel/penable/pwrite/paddr/pwdata/prdata/pready| size, rotate, alpha, length
//
// A render request takes longer in row-major layout than in rotated layout; the 14-step
// restoring divider sets this (one division rotated, two row-major), plus registered
// reads from the text store and the glyph store.
// Reset is synchronous; both stores are unknown until written, so no clearing pass.
// A finished pixel waits in the output register; the sequencer stalls only when a
// second pixel is ready before the first is taken, and requests are taken while idle.
module osd_glyph_text_compositor #(
   parameter int MAX_GLYPH_SIZE = 32,
   parameter int TEXT_SLOTS     = 32
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [3:0]                        req_glyph_index,
   input  logic [8:0]                        req_glyph_offset,
   input  logic [7:0]                        req_glyph_byte,
   input  logic [4:0]                        req_text_slot,
   input  logic [7:0]                        req_char_code,
   input  logic [13:0]                       req_pixel_index,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_low_byte,
   output logic [7:0]                        rsp_high_byte,
   output logic                              rsp_bad_char,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [osdgc_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int DIM_W  = osdgc_pkg::DIM_W;
   localparam int CODE_W = osdgc_pkg::CODE_W;
   localparam int PIX_W  = osdgc_pkg::PIX_W;
   localparam int GBLK   = MAX_GLYPH_SIZE * MAX_GLYPH_SIZE / 2;
   localparam int GA_W   = $clog2(osdgc_pkg::GLYPH_COUNT * GBLK);
   localparam int GO_W   = $clog2(GBLK);
   localparam int TS_AW  = (TEXT_SLOTS > 1) ? $clog2(TEXT_SLOTS) : 1;
   localparam int BLK_W  = $clog2(GBLK + 1);
   localparam int W_W    = $clog2((MAX_GLYPH_SIZE / 2) * TEXT_SLOTS + 1);
   localparam int DEN_W  = (BLK_W > W_W) ? BLK_W : W_W;
   localparam int TOT_W  = $clog2(GBLK * TEXT_SLOTS + 1);
   localparam int CMP_W  = (TOT_W > PIX_W) ? TOT_W : PIX_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_CHECK,
      ST_DIV1,
      ST_DIV2,
      ST_MUL3,
      ST_TXT,
      ST_TXTW,
      ST_GLYW
   } state_type;

   // ---------------- configuration registers ----------------
   logic [5:0] glyph_size_ff;
   logic       rotate_ff;
   logic [7:0] alpha_ff;
   logic [5:0] text_length_ff;
   logic       csr_wr;
   osdgc_pkg::reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = osdgc_pkg::reg_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_size_ff  <= 6'd16;
         rotate_ff      <= 1'b0;
         alpha_ff       <= 8'd0;
         text_length_ff <= 6'd19;
      end else if (csr_wr) begin
         case (csr_idx)
            osdgc_pkg::REG_GLYPH_SIZE:  glyph_size_ff  <= csr_pwdata[5:0];
            osdgc_pkg::REG_ROTATE:      rotate_ff      <= csr_pwdata[0];
            osdgc_pkg::REG_ALPHA:       alpha_ff       <= csr_pwdata[7:0];
            osdgc_pkg::REG_TEXT_LENGTH: text_length_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         osdgc_pkg::REG_GLYPH_SIZE:  csr_prdata = 32'(glyph_size_ff);
         osdgc_pkg::REG_ROTATE:      csr_prdata = 32'(rotate_ff);
         osdgc_pkg::REG_ALPHA:       csr_prdata = 32'(alpha_ff);
         osdgc_pkg::REG_TEXT_LENGTH: csr_prdata = 32'(text_length_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // effective size and length (clamped)
   logic [DIM_W-1:0] size_raw, size_eff, half_eff, len_raw, len_eff;

   always_comb begin
      size_raw = {1'b0, glyph_size_ff & 6'h3E};
      if (size_raw < DIM_W'(2)) begin
         size_eff = DIM_W'(2);
      end else if (size_raw > DIM_W'(MAX_GLYPH_SIZE)) begin
         size_eff = DIM_W'(MAX_GLYPH_SIZE) & ~DIM_W'(1);
      end else begin
         size_eff = size_raw;
      end
      half_eff = size_eff >> 1;

      len_raw = {1'b0, text_length_ff};
      if (len_raw == '0) begin
         len_eff = DIM_W'(1);
      end else if (len_raw > DIM_W'(TEXT_SLOTS)) begin
         len_eff = DIM_W'(TEXT_SLOTS);
      end else begin
         len_eff = len_raw;
      end
   end

   // ---------------- stores ----------------
   logic [7:0]        glyph_mem [osdgc_pkg::GLYPH_COUNT * GBLK];
   logic [CODE_W-1:0] text_mem  [TEXT_SLOTS];
   logic [7:0]        gly_rd_ff;
   logic [CODE_W-1:0] txt_rd_ff;

   state_type         state_ff;
   logic              req_acc;
   logic              glyph_we, text_we, txt_re, gly_re;
   logic [GA_W-1:0]   glyph_wa, glyph_ra;
   logic [DIM_W-1:0]  slot_x;
   logic [DIM_W-1:0]  ch_ff;
   logic [GO_W-1:0]   boff_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign slot_x    = DIM_W'(req_text_slot);

   assign glyph_we = req_acc && (req_cmd == osdgc_pkg::CMD_GLYPH)
                     && (req_glyph_index < osdgc_pkg::CODE_BAD)
                     && (int'(req_glyph_offset) < GBLK);
   assign text_we  = req_acc && (req_cmd == osdgc_pkg::CMD_TEXT)
                     && (slot_x < DIM_W'(TEXT_SLOTS));
   assign txt_re   = (state_ff == ST_TXT);
   assign gly_re   = (state_ff == ST_TXTW) && (txt_rd_ff < osdgc_pkg::CODE_BAD);

   assign glyph_wa = GA_W'(req_glyph_index) * GA_W'(GBLK) + GA_W'(req_glyph_offset);
   assign glyph_ra = GA_W'(txt_rd_ff) * GA_W'(GBLK) + GA_W'(boff_ff);

   always_ff @(posedge clock) begin
      if (glyph_we) begin
         glyph_mem[glyph_wa] <= req_glyph_byte;
      end
      if (gly_re) begin
         gly_rd_ff <= glyph_mem[glyph_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (text_we) begin
         text_mem[slot_x[TS_AW-1:0]] <= osdgc_pkg::char_to_code(req_char_code);
      end
      if (txt_re) begin
         txt_rd_ff <= text_mem[ch_ff[TS_AW-1:0]];
      end
   end

   // ---------------- divider ----------------
   logic              div_start_ff;
   logic [PIX_W-1:0]  div_num_ff;
   logic [DEN_W-1:0]  div_den_ff;
   logic              div_done;
   logic [PIX_W-1:0]  div_quo;
   logic [DEN_W-1:0]  div_rem;

   osdgc_div #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // ---------------- render sequencer ----------------
   logic [PIX_W-1:0]  pix_ff;
   logic [BLK_W-1:0]  blk_ff;
   logic [W_W-1:0]    w_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [DIM_W-1:0]  r_ff;
   logic [DIM_W-1:0]  cmod_ff;
   logic              bad_ff;
   logic              past_ff;
   logic              rsp_valid_ff;
   logic [7:0]        rsp_low_byte_ff;
   logic [7:0]        rsp_high_byte_ff;
   logic              rsp_bad_char_ff;

   logic [7:0]        pix_b;
   logic [7:0]        lo_calc, hi_calc;

   always_comb begin
      pix_b   = bad_ff ? 8'h00 : gly_rd_ff;
      lo_calc = {pix_b[3:2], 2'b00, pix_b[1:0], 2'b00};
      if (alpha_ff != 8'h00) begin
         hi_calc = {alpha_ff[7:4], pix_b[5:4], 2'b00};
      end else begin
         hi_calc = {pix_b[7:6], 2'b00, pix_b[5:4], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && req_cmd == osdgc_pkg::CMD_RENDER) begin
                  pix_ff   <= req_pixel_index;
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               blk_ff   <= BLK_W'(BLK_W'(size_eff) * BLK_W'(half_eff));
               w_ff     <= W_W'(W_W'(half_eff) * W_W'(len_eff));
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               total_ff <= TOT_W'(TOT_W'(blk_ff) * TOT_W'(len_eff));
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               bad_ff <= 1'b0;
               if (CMP_W'(pix_ff) >= CMP_W'(total_ff)) begin
                  past_ff  <= 1'b1;
                  state_ff <= ST_GLYW;
               end else begin
                  past_ff      <= 1'b0;
                  div_start_ff <= 1'b1;
                  div_num_ff   <= pix_ff;
                  div_den_ff   <= rotate_ff ? DEN_W'(blk_ff) : DEN_W'(w_ff);
                  state_ff     <= ST_DIV1;
               end
            end
            ST_DIV1: begin
               if (div_done) begin
                  if (rotate_ff) begin
                     // blocks are stacked last character first
                     ch_ff    <= len_eff - DIM_W'(1) - DIM_W'(div_quo);
                     boff_ff  <= GO_W'(div_rem);
                     state_ff <= ST_TXT;
                  end else begin
                     r_ff         <= DIM_W'(div_quo);
                     div_start_ff <= 1'b1;
                     div_num_ff   <= PIX_W'(div_rem);
                     div_den_ff   <= DEN_W'(half_eff);
                     state_ff     <= ST_DIV2;
                  end
               end
            end
            ST_DIV2: begin
               if (div_done) begin
                  ch_ff    <= DIM_W'(div_quo);
                  cmod_ff  <= DIM_W'(div_rem);
                  state_ff <= ST_MUL3;
               end
            end
            ST_MUL3: begin
               boff_ff  <= GO_W'(BLK_W'(r_ff) * BLK_W'(half_eff) + BLK_W'(cmod_ff));
               state_ff <= ST_TXT;
            end
            ST_TXT: begin
               state_ff <= ST_TXTW;
            end
            ST_TXTW: begin
               bad_ff   <= !(txt_rd_ff < osdgc_pkg::CODE_BAD);
               state_ff <= ST_GLYW;
            end
            ST_GLYW: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (past_ff) begin
                     rsp_low_byte_ff  <= 8'h00;
                     rsp_high_byte_ff <= 8'h00;
                     rsp_bad_char_ff  <= 1'b0;
                  end else begin
                     rsp_low_byte_ff  <= lo_calc;
                     rsp_high_byte_ff <= hi_calc;
                     rsp_bad_char_ff  <= bad_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_low_byte  = rsp_low_byte_ff;
   assign rsp_high_byte = rsp_high_byte_ff;
   assign rsp_bad_char  = rsp_bad_char_ff;

   // ---------------- assertions ----------------
   `OSD_ASSERT(a_rsp_from_glyph_read, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_GLYW), "response raised outside glyph read state")
   `OSD_ASSERT(a_div_done_waited, clock, reset, div_done |-> (state_ff == ST_DIV1 || state_ff == ST_DIV2), "divider finished with no one waiting")
   `OSD_ASSERT(a_bad_char_blank, clock, reset, (rsp_valid_ff && rsp_bad_char_ff) |-> (rsp_low_byte_ff == 8'h00), "bad character produced color bits")
   `OSD_ASSERT_NEXT(a_render_starts, clock, reset, req_valid && req_ready && req_cmd == osdgc_pkg::CMD_RENDER, state_ff == ST_MUL1, "render request did not start sequencer")

endmodule
